[hw/rtl/vrt_pkg.sv]
// Package for the voxel ray traversal unit: payload types, command and status
// structs, register indexes and the product pair table. No dependencies.
`timescale 1ns / 1ps

package vrt_pkg;

   localparam int POS_W   = 24;   // Q.8 start coordinate
   localparam int DIR_W   = 16;   // Q1.14 direction component
   localparam int SPD_W   = 16;   // magnitude of a direction component
   localparam int CELL_W  = 16;   // wrapped cell index
   localparam int IDX_W   = 6;    // step index along the ray
   localparam int COUNT_W = 7;    // step_count register
   localparam int EYE_W   = 10;   // eye_offset register
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int SEL_W   = 3;    // selects one of the six cross products
   localparam int NUM_PAIRS = 6;

   localparam int MAX_STEPS_DEFAULT = 64;

   localparam logic [COUNT_W-1:0] STEP_COUNT_RESET = 7'd20;
   localparam logic [EYE_W-1:0]   EYE_OFFSET_RESET = 10'd0;

   // Register indexes on the configuration channel.
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COUNT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_OFFSET = 8'd1;

   // Axis codes.
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Cross products num[a] * spd[b], one slot per ordered axis pair.
   localparam logic [SEL_W-1:0] P_XY = 3'd0;
   localparam logic [SEL_W-1:0] P_YX = 3'd1;
   localparam logic [SEL_W-1:0] P_XZ = 3'd2;
   localparam logic [SEL_W-1:0] P_ZX = 3'd3;
   localparam logic [SEL_W-1:0] P_YZ = 3'd4;
   localparam logic [SEL_W-1:0] P_ZY = 3'd5;
   localparam logic [SEL_W-1:0] P_LAST = 3'd5;

   typedef struct packed {
      logic signed [POS_W-1:0] start_x;
      logic signed [POS_W-1:0] start_y;
      logic signed [POS_W-1:0] start_z;
      logic signed [DIR_W-1:0] dir_x;
      logic signed [DIR_W-1:0] dir_y;
      logic signed [DIR_W-1:0] dir_z;
   } vrt_req_type;

   typedef struct packed {
      logic signed [CELL_W-1:0] cell_x;
      logic signed [CELL_W-1:0] cell_y;
      logic signed [CELL_W-1:0] cell_z;
      logic [IDX_W-1:0]         step_index;
      logic                     last_cell;
   } vrt_rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [CSR_DAT_W-1:0] value;
   } vrt_csr_type;

   typedef struct packed {
      logic             load;
      logic             mul_en;
      logic [SEL_W-1:0] mul_sel;
      logic             step;
   } vrt_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic last;
   } vrt_sts_type;

   // Axis whose distance is the first factor of a product slot.
   function automatic logic [1:0] pair_num(input logic [SEL_W-1:0] sel);
      logic [1:0] ax;
      unique case (sel)
         P_XY, P_XZ: ax = AXIS_X;
         P_YX, P_YZ: ax = AXIS_Y;
         default:    ax = AXIS_Z;
      endcase
      return ax;
   endfunction

   // Axis whose speed is the second factor of a product slot.
   function automatic logic [1:0] pair_spd(input logic [SEL_W-1:0] sel);
      logic [1:0] ax;
      unique case (sel)
         P_YX, P_ZX: ax = AXIS_X;
         P_XY, P_ZY: ax = AXIS_Y;
         default:    ax = AXIS_Z;
      endcase
      return ax;
   endfunction

endpackage

[hw/rtl/vrt_chan_if.sv]
// Valid/ready channel interface used for the ray, cell and register channels.
// The payload type comes from vrt_pkg.
`timescale 1ns / 1ps

interface vrt_chan_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/vrt_ctrl.sv]
// Controller state machine of the voxel ray traversal unit.
// Depends on vrt_pkg for the command and status structs.
`timescale 1ns / 1ps

module vrt_ctrl
   import vrt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  vrt_sts_type sts,
   output vrt_cmd_type cmd
);

   typedef enum logic [1:0] {
      IDLE,
      MUL,
      EMIT
   } state_type;

   state_type        state_ff, state_in;
   logic [SEL_W-1:0] mcnt_ff, mcnt_in;
   logic             rdy_ff, rdy_in;
   logic             vld_ff, vld_in;

   always_comb begin
      state_in = state_ff;
      mcnt_in  = mcnt_ff;
      rdy_in   = rdy_ff;
      vld_in   = vld_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_valid && rdy_ff) begin
               state_in = MUL;
               mcnt_in  = '0;
               rdy_in   = 1'b0;
            end
         end
         MUL: begin
            if (mcnt_ff == P_LAST) begin
               if (sts.count_zero) begin
                  state_in = IDLE;
                  rdy_in   = 1'b1;
               end else begin
                  state_in = EMIT;
                  vld_in   = 1'b1;
               end
            end else begin
               mcnt_in = mcnt_ff + SEL_W'(1);
            end
         end
         EMIT: begin
            if (rsp_ready && sts.last) begin
               state_in = IDLE;
               vld_in   = 1'b0;
               rdy_in   = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
            rdy_in   = 1'b1;
            vld_in   = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         mcnt_ff  <= '0;
         rdy_ff   <= 1'b1;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         mcnt_ff  <= mcnt_in;
         rdy_ff   <= rdy_in;
         vld_ff   <= vld_in;
      end
   end

   assign req_ready   = rdy_ff;
   assign rsp_valid   = vld_ff;
   assign cmd.load    = req_valid && rdy_ff;
   assign cmd.mul_en  = (state_ff == MUL);
   assign cmd.mul_sel = mcnt_ff;
   assign cmd.step    = vld_ff && rsp_ready;

`ifndef SYNTHESIS
   // A ray is never accepted while a cell is being offered.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rdy_ff && vld_ff))
      else $error("vrt_ctrl: ready and valid high together");

   // Every accepted ray starts the product setup on the next cycle.
   a_load_to_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == MUL) && (mcnt_ff == '0))
      else $error("vrt_ctrl: accepted ray did not enter product setup");

   // A taken cell that is not the last keeps the channel valid.
   a_keep_emitting: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !sts.last) |=> vld_ff)
      else $error("vrt_ctrl: cell run ended early");

   // Nothing is emitted for a ray with a zero step count.
   a_zero_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MUL && mcnt_ff == P_LAST && sts.count_zero) |=> !vld_ff)
      else $error("vrt_ctrl: cell emitted for empty run");
`endif

endmodule

[hw/rtl/vrt_dpath.sv]
// Datapath of the voxel ray traversal unit: start cell, boundary distances,
// one shared multiplier for the six cross products, and the per-cell stepper.
// Depends on vrt_pkg.
`timescale 1ns / 1ps

module vrt_dpath
   import vrt_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEFAULT
) (
   input  logic               clock,
   input  vrt_cmd_type        cmd,
   output vrt_sts_type        sts,
   input  vrt_req_type        req_data,
   input  logic [EYE_W-1:0]   eye_offset,
   input  logic [COUNT_W-1:0] step_count,
   output vrt_rsp_type        rsp_data
);

   // The distance numerator grows by one cell per step over the run.
   localparam int NUM_W  = $clog2(256 * (MAX_STEPS + 1) + 1);
   localparam int PROD_W = NUM_W + SPD_W;
   localparam int WPOS_W = POS_W + 1;

   logic signed [WPOS_W-1:0] pos [3];
   logic signed [DIR_W-1:0]  dir [3];
   logic [CELL_W-1:0]        cell_ld [3];
   logic [NUM_W-1:0]         num_ld [3];
   logic [SPD_W-1:0]         spd_ld [3];
   logic                     up_ld [3];
   logic                     dn_ld [3];

   logic [CELL_W-1:0]  cell_ff [3];
   logic [NUM_W-1:0]   num_ff [3];
   logic [SPD_W-1:0]   spd_ff [3];
   logic               up_ff [3];
   logic               dn_ff [3];
   logic [PROD_W-1:0]  prod_ff [NUM_PAIRS];
   logic [PROD_W-1:0]  prod_in [NUM_PAIRS];
   logic [CELL_W-1:0]  cell_in [3];
   logic [COUNT_W-1:0] count_ff;
   logic [IDX_W-1:0]   k_ff;

   logic [NUM_W-1:0]  mul_a;
   logic [SPD_W-1:0]  mul_b;
   logic [PROD_W-1:0] mul_p;
   logic              le_xy, le_xz, le_yz;
   logic [1:0]        ax;

   // Start position, cell and boundary distance for each axis.
   always_comb begin
      pos[0] = {req_data.start_x[POS_W-1], req_data.start_x};
      pos[1] = {req_data.start_y[POS_W-1], req_data.start_y}
             + $signed({{(WPOS_W-EYE_W){1'b0}}, eye_offset});
      pos[2] = {req_data.start_z[POS_W-1], req_data.start_z};
      dir[0] = req_data.dir_x;
      dir[1] = req_data.dir_y;
      dir[2] = req_data.dir_z;
      for (int a = 0; a < 3; a++) begin
         cell_ld[a] = pos[a][8 +: CELL_W];
         up_ld[a]   = !dir[a][DIR_W-1] && (dir[a] != '0);
         dn_ld[a]   = dir[a][DIR_W-1];
         if (up_ld[a]) begin
            spd_ld[a] = SPD_W'(dir[a]);
            num_ld[a] = NUM_W'(9'd256 - {1'b0, pos[a][7:0]});
         end else if (dn_ld[a]) begin
            spd_ld[a] = SPD_W'(-dir[a]);
            num_ld[a] = NUM_W'(pos[a][7:0]);
         end else begin
            spd_ld[a] = '0;
            num_ld[a] = '0;
         end
      end
   end

   // Shared multiplier for the product setup.
   assign mul_a = num_ff[pair_num(cmd.mul_sel)];
   assign mul_b = spd_ff[pair_spd(cmd.mul_sel)];
   assign mul_p = PROD_W'(mul_a * mul_b);

   // Crossing time compare: a zero speed means an infinite time.
   assign le_xy = (spd_ff[AXIS_Y] == '0) ||
                  ((spd_ff[AXIS_X] != '0) && (prod_ff[P_XY] <= prod_ff[P_YX]));
   assign le_xz = (spd_ff[AXIS_Z] == '0) ||
                  ((spd_ff[AXIS_X] != '0) && (prod_ff[P_XZ] <= prod_ff[P_ZX]));
   assign le_yz = (spd_ff[AXIS_Z] == '0) ||
                  ((spd_ff[AXIS_Y] != '0) && (prod_ff[P_YZ] <= prod_ff[P_ZY]));

   always_comb begin
      if (le_xy && le_xz) begin
         ax = AXIS_X;
      end else if (le_yz) begin
         ax = AXIS_Y;
      end else begin
         ax = AXIS_Z;
      end
      // Moving one cell on an axis adds one cell width to its distance.
      for (int p = 0; p < NUM_PAIRS; p++) begin
         if (pair_num(SEL_W'(p)) == ax) begin
            prod_in[p] = prod_ff[p] + {spd_ff[pair_spd(SEL_W'(p))], 8'd0};
         end else begin
            prod_in[p] = prod_ff[p];
         end
      end
      for (int a = 0; a < 3; a++) begin
         cell_in[a] = cell_ff[a];
         if (ax == 2'(a)) begin
            if (up_ff[a]) begin
               cell_in[a] = cell_ff[a] + CELL_W'(1);
            end else if (dn_ff[a]) begin
               cell_in[a] = cell_ff[a] - CELL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         for (int a = 0; a < 3; a++) begin
            cell_ff[a] <= cell_ld[a];
            num_ff[a]  <= num_ld[a];
            spd_ff[a]  <= spd_ld[a];
            up_ff[a]   <= up_ld[a];
            dn_ff[a]   <= dn_ld[a];
         end
         count_ff <= (step_count > COUNT_W'(MAX_STEPS)) ? COUNT_W'(MAX_STEPS) : step_count;
         k_ff     <= '0;
      end
      if (cmd.mul_en) begin
         for (int p = 0; p < NUM_PAIRS; p++) begin
            if (cmd.mul_sel == SEL_W'(p)) begin
               prod_ff[p] <= mul_p;
            end
         end
      end
      if (cmd.step) begin
         for (int p = 0; p < NUM_PAIRS; p++) begin
            prod_ff[p] <= prod_in[p];
         end
         for (int a = 0; a < 3; a++) begin
            cell_ff[a] <= cell_in[a];
         end
         k_ff <= k_ff + IDX_W'(1);
      end
   end

   assign sts.count_zero = (count_ff == '0);
   assign sts.last       = (({1'b0, k_ff} + COUNT_W'(1)) == count_ff);

   assign rsp_data.cell_x     = cell_ff[AXIS_X];
   assign rsp_data.cell_y     = cell_ff[AXIS_Y];
   assign rsp_data.cell_z     = cell_ff[AXIS_Z];
   assign rsp_data.step_index = k_ff;
   assign rsp_data.last_cell  = sts.last;

endmodule

[hw/rtl/voxel_ray_traversal_unit.sv]
// After a ray is accepted, the product setup runs on the single shared multiplier,
// and then one cell is offered per cycle while the result channel is ready. The next
// ray is accepted only once the last cell of the run has been taken. A ray whose step
// count is zero yields no cells and frees the input after the product setup.
// Reset is synchronous and active high; it restores step_count to 20 and eye_offset to 0.
// Depends on vrt_pkg, vrt_chan_if, vrt_ctrl and vrt_dpath.
`timescale 1ns / 1ps

module voxel_ray_traversal_unit
   import vrt_pkg::*;
#(
   parameter int MAX_STEPS = MAX_STEPS_DEFAULT
) (
   input logic clock,
   input logic reset,
   vrt_chan_if.sink   req_chan,
   vrt_chan_if.source rsp_chan,
   vrt_chan_if.sink   csr_chan
);

   // The unit walks a ray through a grid of unit voxel cells. On acceptance the
   // datapath latches the start cell (the start y is raised by the eye offset),
   // the distance to the next cell boundary on each axis, and the magnitude of
   // each direction component. The controller then steps the shared multiplier
   // through the product slots to form the cross products num[a] * speed[b] for
   // every ordered pair of axes. Comparing them decides which boundary is
   // crossed first without any division.
   //
   // Once the products are ready, the unit offers one cell per cycle while the
   // result channel is ready. For each taken cell the chosen axis moves one
   // cell and its products grow by one cell width times the other axis speed,
   // so no further multiplies are needed. Ties go to x, then y, then z; an axis
   // with a zero component never moves. The cell registers drive the result
   // channel directly, and the input stays closed until the last cell is taken.

   logic [COUNT_W-1:0] step_count_ff, step_count_in;
   logic [EYE_W-1:0]   eye_offset_ff, eye_offset_in;
   logic               csr_write;

   vrt_cmd_type cmd;
   vrt_sts_type sts;
   vrt_rsp_type rsp_data;

   // Register writes are always accepted; unknown indexes are dropped.
   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid;

   always_comb begin
      step_count_in = step_count_ff;
      eye_offset_in = eye_offset_ff;
      if (csr_write) begin
         unique case (csr_chan.data.index)
            CSR_STEP_COUNT: step_count_in = csr_chan.data.value[COUNT_W-1:0];
            CSR_EYE_OFFSET: eye_offset_in = csr_chan.data.value[EYE_W-1:0];
            default: begin
               step_count_in = step_count_ff;
               eye_offset_in = eye_offset_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_count_ff <= STEP_COUNT_RESET;
         eye_offset_ff <= EYE_OFFSET_RESET;
      end else begin
         step_count_ff <= step_count_in;
         eye_offset_ff <= eye_offset_in;
      end
   end

   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vrt_dpath #(
      .MAX_STEPS (MAX_STEPS)
   ) u_dpath (
      .clock      (clock),
      .cmd        (cmd),
      .sts        (sts),
      .req_data   (req_chan.data),
      .eye_offset (eye_offset_ff),
      .step_count (step_count_ff),
      .rsp_data   (rsp_data)
   );

   assign rsp_chan.data = rsp_data;

endmodule
